// File: rtl/rfpd_pkg.sv
package rfpd_pkg;

  // Detector characteristic
  localparam int QUIESCENT_MV    = 2100;
  localparam int INTERCEPT_DBM   = 0;
  localparam int SLOPE_MV_PER_DB = -24;

  // Power clamp in sixteenths of a dBm
  localparam int DBM_Q4_MIN = -1040;
  localparam int DBM_Q4_MAX = 80;

  // Threat span limits, Q8 millivolts
  localparam int SPAN_MIN_Q8      = 10 * 256;
  localparam int SPAN_FALLBACK_Q8 = 1600 * 256;
  localparam int THREAT_FULL      = 1000;

  // Shared divider: dividend holds the dBm numerator or (clean - avg) * 1000, divisor the dBm step or a Q8 span
  localparam int DVD_W = 30;
  localparam int DVS_W = 20;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SEED   = 2'd1,
    CMD_CAL    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_ALPHA    = 3'd0;
  localparam logic [2:0] REG_BURST    = 3'd1;
  localparam logic [2:0] REG_SAT      = 3'd2;
  localparam logic [2:0] REG_DEADBAND = 3'd3;
  localparam logic [2:0] REG_TRIGGER  = 3'd4;
  localparam logic [2:0] REG_RELEASE  = 3'd5;
  localparam logic [2:0] REG_PERSIST  = 3'd6;
  localparam logic [2:0] REG_HOLD     = 3'd7;

  typedef struct packed {
    logic [8:0]  ema_alpha_q8;    // already limited to 1..256
    logic [11:0] burst_drop_mv;
    logic [11:0] saturated_mv;
    logic [9:0]  deadband_tenths;
    logic [9:0]  trigger_tenths;
    logic [9:0]  release_tenths;
    logic [15:0] persist_ms;
    logic [15:0] hold_ms;
  } cfg_t;

endpackage

// File: rtl/rfpd_cfg.sv
module rfpd_cfg
  import rfpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  logic [8:0]  alpha_r;
  logic [11:0] burst_drop_r;
  logic [11:0] sat_r;
  logic [9:0]  deadband_r;
  logic [9:0]  trigger_r;
  logic [9:0]  release_r;
  logic [15:0] persist_r;
  logic [15:0] hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= 9'd26;
      burst_drop_r <= 12'd50;
      sat_r        <= 12'd500;
      deadband_r   <= 10'd20;
      trigger_r    <= 10'd300;
      release_r    <= 10'd150;
      persist_r    <= 16'd500;
      hold_r       <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ALPHA:    alpha_r      <= cfg_wdata[8:0];
        REG_BURST:    burst_drop_r <= cfg_wdata[11:0];
        REG_SAT:      sat_r        <= cfg_wdata[11:0];
        REG_DEADBAND: deadband_r   <= cfg_wdata[9:0];
        REG_TRIGGER:  trigger_r    <= cfg_wdata[9:0];
        REG_RELEASE:  release_r    <= cfg_wdata[9:0];
        REG_PERSIST:  persist_r    <= cfg_wdata;
        REG_HOLD:     hold_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    // Zero weight acts as one, anything above unity acts as unity
    if (alpha_r == 9'd0) begin
      cfg.ema_alpha_q8 = 9'd1;
    end else if (alpha_r > 9'd256) begin
      cfg.ema_alpha_q8 = 9'd256;
    end else begin
      cfg.ema_alpha_q8 = alpha_r;
    end
    cfg.burst_drop_mv   = burst_drop_r;
    cfg.saturated_mv    = sat_r;
    cfg.deadband_tenths = deadband_r;
    cfg.trigger_tenths  = trigger_r;
    cfg.release_tenths  = release_r;
    cfg.persist_ms      = persist_r;
    cfg.hold_ms         = hold_r;
  end

endmodule

// File: rtl/rfpd_div.sv
module rfpd_div
  import rfpd_pkg::*;
#(
  parameter int DIVIDEND_W = DVD_W,   // even
  parameter int DIVISOR_W  = DVS_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEPS  = 2;
  localparam int CYCLES = DIVIDEND_W / STEPS;
  localparam int CNT_W  = $clog2(CYCLES + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_nxt;

  // Two restoring steps a cycle: quotient bits shift in as dividend bits shift out
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial   = {rem_nxt, quo_nxt[DIVIDEND_W-1]};
      quo_nxt = {quo_nxt[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CYCLES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end else if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/rf_power_detector_with_persistence.sv
// Channel | Ports        | Word layout
// --------+--------------+------------------------------------------------------
// input   | in_t*        | tdata: sample_mv[11:0], now_ms[43:12]; tuser: cmd[1:0]
// output  | out_t*       | tdata: filtered_q8[19:0], power_dbm_q4[31:20],
//         |              |        threat_tenths[41:32]; tuser: burst, incoming
// config  | cfg_we/addr  | one register written per cycle, no read-back
//
// An accepted word runs the moving-average multiply and bookkeeping, then the shared
// divider runs twice (dBm quotient, threat ratio) at two quotient bits a cycle.
// in_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next word is taken while it waits.
// Reset (rst_n low at a clock edge) loads the quiescent references and clears
// the alarm, the candidate timer and the output valid flag.
module rf_power_detector_with_persistence
  import rfpd_pkg::*;
#(
  parameter int P_QUIESCENT_MV    = QUIESCENT_MV,
  parameter int P_INTERCEPT_DBM   = INTERCEPT_DBM,
  parameter int P_SLOPE_MV_PER_DB = SLOPE_MV_PER_DB   // negative
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // sample_mv[11:0], now_ms[43:12], zero pad
  input  logic [1:0]  in_tuser,     // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // filtered_q8[19:0], power_dbm_q4[31:20],
                                    // threat_tenths[41:32], zero pad
  output logic [1:0]  out_tuser,    // burst[0], incoming[1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int DBM_DIV = -16 * P_SLOPE_MV_PER_DB;

  localparam logic [19:0]          QUIESCENT_Q8 = 20'(P_QUIESCENT_MV * 256);
  localparam logic [11:0]          QUIESCENT    = 12'(P_QUIESCENT_MV);
  localparam logic [DVS_W-1:0]     DBM_DIVISOR  = DVS_W'(DBM_DIV);
  localparam logic [DVD_W-1:0]     DBM_HALF     = DVD_W'(DBM_DIV / 2);
  localparam logic signed [15:0]   ICPT_Q4      = 16'(P_INTERCEPT_DBM * 16);
  localparam logic signed [15:0]   DBM_LO       = 16'(DBM_Q4_MIN);
  localparam logic signed [15:0]   DBM_HI       = 16'(DBM_Q4_MAX);
  localparam logic signed [20:0]   SPAN_MIN     = 21'(SPAN_MIN_Q8);
  localparam logic [DVS_W-1:0]     SPAN_FALL    = DVS_W'(SPAN_FALLBACK_Q8);
  localparam logic [9:0]           THR_FULL     = 10'(THREAT_FULL);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_UPD  = 8'b0000_0100,
    S_DBM  = 8'b0000_1000,
    S_DBMW = 8'b0001_0000,
    S_THRW = 8'b0010_0000,
    S_ALM  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  cfg_t cfg;

  rfpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t state_r, state_nxt;

  cmd_t        cmd_r;
  logic [11:0] smp_r;
  logic [31:0] now_r;
  logic [19:0] avg_r;
  logic [11:0] prior_r;
  logic [19:0] clean_r;
  logic        alarm_r;
  logic        cand_vld_r;
  logic [31:0] cand_start_r;
  logic [31:0] last_act_r;
  logic [28:0] prod_r;
  logic        burst_r;
  logic        neg_r;
  logic [11:0] dbm_r;
  logic [9:0]  threat_r;
  logic        out_vld_r;
  logic [47:0] out_data_r;
  logic [1:0]  out_user_r;

  // Shared divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  rfpd_div #(
    .DIVIDEND_W (DVD_W),
    .DIVISOR_W  (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Shared multiplier: avg * (256 - alpha) first, then sample * alpha
  logic [19:0] mul_a;
  logic [8:0]  mul_b;
  logic [28:0] mul_p;
  logic [29:0] ema_sum;

  always_comb begin
    if (state_r == S_MUL) begin
      mul_a = avg_r;
      mul_b = 9'd256 - cfg.ema_alpha_q8;
    end else begin
      mul_a = {8'd0, smp_r};
      mul_b = cfg.ema_alpha_q8;
    end
  end

  assign mul_p   = 29'(mul_a * mul_b);
  assign ema_sum = {1'b0, prod_r} + {1'b0, mul_p[20:0], 8'd0} + 30'd128;

  logic signed [12:0] drop;
  assign drop = $signed({1'b0, prior_r}) - $signed({1'b0, smp_r});

  // dBm numerator, sign flipped by the negative slope
  logic [19:0]        sat_q8;
  logic signed [20:0] dbm_num;
  logic [20:0]        dbm_mag;
  assign sat_q8  = {cfg.saturated_mv, 8'd0};
  assign dbm_num = $signed({1'b0, sat_q8}) - $signed({1'b0, avg_r});
  assign dbm_mag = dbm_num[20] ? 21'(-dbm_num) : dbm_num;

  // Rounded quotient, signed and offset by the intercept; clamped when latched
  logic signed [15:0] dbm_q;
  logic signed [15:0] dbm_v;
  always_comb begin
    dbm_q = $signed({1'b0, div_quo[14:0]});
    if (neg_r) begin
      dbm_q = -dbm_q;
    end
    dbm_v = ICPT_Q4 + dbm_q;
  end

  // Threat ratio operands
  logic signed [20:0] span;
  logic [19:0]        clean_gap;
  logic [DVS_W-1:0]   thr_dvs;
  logic [DVD_W-1:0]   thr_dvd;
  assign span      = $signed({1'b0, clean_r}) - $signed({1'b0, sat_q8});
  assign clean_gap = (clean_r > avg_r) ? (clean_r - avg_r) : 20'd0;
  assign thr_dvs   = (span <= SPAN_MIN) ? SPAN_FALL : span[DVS_W-1:0];
  assign thr_dvd   = DVD_W'({10'd0, clean_gap} * 30'd1000);

  logic [9:0] thr_raw;
  always_comb begin
    if (avg_r >= clean_r) begin
      thr_raw = 10'd0;
    end else if (avg_r <= sat_q8) begin
      thr_raw = THR_FULL;
    end else if (div_quo > DVD_W'(THREAT_FULL)) begin
      thr_raw = THR_FULL;
    end else begin
      thr_raw = div_quo[9:0];
    end
  end

  // Persistence and hold timing, modulo 2^32
  logic [31:0] cand_age;
  logic [31:0] idle_age;
  assign cand_age = cand_vld_r ? (now_r - cand_start_r) : 32'd0;
  assign idle_age = now_r - last_act_r;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {{(DVD_W-21){1'b0}}, dbm_mag} + DBM_HALF;
    div_dvs   = DBM_DIVISOR;
    if (state_r == S_DBM) begin
      div_start = 1'b1;
    end else if (state_r == S_DBMW) begin
      div_start = div_done;
      div_dvd   = thr_dvd;
      div_dvs   = thr_dvs;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_DBM;
      S_DBM:  state_nxt = S_DBMW;
      S_DBMW: if (div_done) state_nxt = S_THRW;
      S_THRW: if (div_done) state_nxt = S_ALM;
      S_ALM:  state_nxt = S_OUT;
      S_OUT:  if (!out_vld_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the word and the per-word intermediates
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r <= cmd_t'(in_tuser);
      smp_r <= in_tdata[11:0];
      now_r <= in_tdata[43:12];
    end
    if (state_r == S_MUL) begin
      prod_r <= mul_p;
    end
    if (state_r == S_UPD) begin
      burst_r <= (cmd_r == CMD_SAMPLE) && (drop >= $signed({1'b0, cfg.burst_drop_mv}));
    end
    if (state_r == S_DBM) begin
      neg_r <= dbm_num[20];
    end
    if (state_r == S_DBMW && div_done) begin
      if (dbm_v < DBM_LO) begin
        dbm_r <= DBM_LO[11:0];
      end else if (dbm_v > DBM_HI) begin
        dbm_r <= DBM_HI[11:0];
      end else begin
        dbm_r <= dbm_v[11:0];
      end
    end
    if (state_r == S_THRW && div_done) begin
      threat_r <= (thr_raw < cfg.deadband_tenths) ? 10'd0 : thr_raw;
    end
  end

  // Filter state and alarm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r        <= QUIESCENT_Q8;
      prior_r      <= QUIESCENT;
      clean_r      <= QUIESCENT_Q8;
      alarm_r      <= 1'b0;
      cand_vld_r   <= 1'b0;
      cand_start_r <= 32'd0;
      last_act_r   <= 32'd0;
    end else begin
      if (state_r == S_UPD) begin
        unique case (cmd_r)
          CMD_SAMPLE: begin
            prior_r <= smp_r;
            avg_r   <= ema_sum[27:8];
          end
          CMD_SEED: begin
            avg_r   <= {smp_r, 8'd0};
            prior_r <= smp_r;
            clean_r <= {smp_r, 8'd0};
          end
          CMD_CAL: clean_r <= avg_r;
          CMD_NONE: ;
          default: ;
        endcase
      end
      if (state_r == S_ALM && cmd_r == CMD_SAMPLE) begin
        if (threat_r >= cfg.trigger_tenths) begin
          if (!cand_vld_r) begin
            cand_vld_r   <= 1'b1;
            cand_start_r <= now_r;
          end
          if (cand_age >= {16'd0, cfg.persist_ms}) begin
            alarm_r    <= 1'b1;
            last_act_r <= now_r;
          end
        end else begin
          cand_vld_r   <= 1'b0;
          cand_start_r <= 32'd0;
          if (threat_r <= cfg.release_tenths && idle_age >= {16'd0, cfg.hold_ms}) begin
            alarm_r <= 1'b0;
          end
        end
      end
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_vld_r || out_tready)) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_vld_r || out_tready)) begin
      out_data_r <= {6'd0, threat_r, dbm_r, avg_r};
      out_user_r <= {alarm_r, burst_r};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/rfpd_checker.sv
module rfpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A taken word keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous word still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_threat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[41:32] <= 10'd1000)
    else $error("threat above full scale");

  a_power_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:20]) >= -12'sd1040)
                   && ($signed(out_tdata[31:20]) <= 12'sd80))
    else $error("power outside clamp");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind rf_power_detector_with_persistence rfpd_checker u_rfpd_checker (.*);

// File: dv/tb_rf_power_detector_with_persistence.sv
module tb_rf_power_detector_with_persistence;
  timeunit 1ns;
  timeprecision 1ps;

  import rfpd_pkg::*;

  localparam int RUN_LIMIT = 1_000_000;

  typedef struct packed {
    logic [19:0] filtered_q8;
    logic [11:0] power_dbm_q4;
    logic [9:0]  threat_tenths;
    logic        burst;
    logic        incoming;
  } reading_t;

  typedef struct {
    logic [8:0]  alpha;
    logic [11:0] drop_mv;
    logic [11:0] sat_mv;
    logic [9:0]  deadband;
    logic [9:0]  trigger;
    logic [9:0]  rel_tenths;
    logic [15:0] persist;
    logic [15:0] hold;
  } detector_regs_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;     // sample_mv[11:0], now_ms[43:12], zero pad
  logic [1:0]  in_tuser;     // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;    // filtered_q8[19:0], power_dbm_q4[31:20], threat_tenths[41:32]
  logic [1:0]  out_tuser;    // burst[0], incoming[1]
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  // Detector state as the block should hold it
  detector_regs_t dc;
  logic [19:0]    avg_q8;
  logic [19:0]    clean_q8;
  logic [11:0]    prior_mv;
  logic           alarm_on;
  logic           cand_live;
  logic [31:0]    cand_t0;
  logic [31:0]    active_t;

  reading_t    readings_due[$];
  int          mismatches;
  int          readings_seen;
  int          src_idle;
  int          snk_idle;
  logic        hold_back;

  // Traffic generator state
  logic [31:0] clock_ms;
  int          target_mv;
  bit          strong_rf;

  rf_power_detector_with_persistence i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic void detector_step(input cmd_t c, input logic [11:0] mv,
                                        input logic [31:0] t, output reading_t r);
    longint      a, num, den, q, pwr, sat, clean, avg, span, thr;
    logic [31:0] since;
    r.burst = 1'b0;
    a = dc.alpha;
    if (a < 1) a = 1;
    else if (a > 256) a = 256;
    case (c)
      CMD_SAMPLE: begin
        r.burst = (longint'(prior_mv) - longint'(mv) >= longint'(dc.drop_mv));
        prior_mv = mv;
        avg_q8 = 20'((longint'(avg_q8) * (256 - a) + longint'(mv) * 256 * a + 128) >> 8);
      end
      CMD_SEED: begin
        avg_q8   = {mv, 8'd0};
        prior_mv = mv;
        clean_q8 = {mv, 8'd0};
      end
      CMD_CAL: clean_q8 = avg_q8;
      default: ;
    endcase

    // dBm estimate, quotient rounded to nearest with ties away from zero
    num = longint'(avg_q8) - longint'(dc.sat_mv) * 256;
    den = 16 * SLOPE_MV_PER_DB;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    q = (num >= 0) ? (num + den / 2) / den : -((-num + den / 2) / den);
    pwr = INTERCEPT_DBM * 16 + q;
    if (pwr < DBM_Q4_MIN) pwr = DBM_Q4_MIN;
    if (pwr > DBM_Q4_MAX) pwr = DBM_Q4_MAX;

    sat   = longint'(dc.sat_mv) * 256;
    clean = longint'(clean_q8);
    avg   = longint'(avg_q8);
    span  = clean - sat;
    if (span <= SPAN_MIN_Q8) span = SPAN_FALLBACK_Q8;
    if (avg >= clean) thr = 0;
    else if (avg <= sat) thr = THREAT_FULL;
    else begin
      thr = (clean - avg) * 1000 / span;
      if (thr > THREAT_FULL) thr = THREAT_FULL;
    end
    if (thr < longint'(dc.deadband)) thr = 0;

    // Persistence and hysteresis run on samples only
    if (c == CMD_SAMPLE) begin
      if (thr >= longint'(dc.trigger)) begin
        if (!cand_live) begin
          cand_live = 1'b1;
          cand_t0   = t;
        end
        since = t - cand_t0;
        if (since >= dc.persist) begin
          alarm_on = 1'b1;
          active_t = t;
        end
      end else begin
        cand_live = 1'b0;
        cand_t0   = '0;
        since     = t - active_t;
        if (thr <= longint'(dc.rel_tenths) && since >= dc.hold) alarm_on = 1'b0;
      end
    end

    r.filtered_q8   = avg_q8;
    r.power_dbm_q4  = 12'(pwr);
    r.threat_tenths = 10'(thr);
    r.incoming      = alarm_on;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] reading %0d: %s got %0d expected %0d",
               $time, readings_seen, what, got, want);
  endtask

  task automatic offer_sample(input cmd_t c, input logic [11:0] mv, input logic [31:0] t);
    reading_t r;
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, t, mv};
    in_tuser  <= c;
    do @(posedge clk); while (!in_tready);
    detector_step(c, mv, t, r);
    readings_due.push_back(r);
  endtask

  // Drop valid and wait for every reading still owed
  task automatic drain_readings();
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input int alpha, drop, sat, deadband, trigger, rel,
                              persist, hold);
    logic [15:0] vals [8];
    vals[REG_ALPHA]    = 16'(alpha);
    vals[REG_BURST]    = 16'(drop);
    vals[REG_SAT]      = 16'(sat);
    vals[REG_DEADBAND] = 16'(deadband);
    vals[REG_TRIGGER]  = 16'(trigger);
    vals[REG_RELEASE]  = 16'(rel);
    vals[REG_PERSIST]  = 16'(persist);
    vals[REG_HOLD]     = 16'(hold);
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    dc.alpha      = vals[REG_ALPHA][8:0];
    dc.drop_mv    = vals[REG_BURST][11:0];
    dc.sat_mv     = vals[REG_SAT][11:0];
    dc.deadband   = vals[REG_DEADBAND][9:0];
    dc.trigger    = vals[REG_TRIGGER][9:0];
    dc.rel_tenths = vals[REG_RELEASE][9:0];
    dc.persist    = vals[REG_PERSIST];
    dc.hold       = vals[REG_HOLD];
  endtask

  // Mostly runs of strong or clean-air samples with rising timestamps, some noise
  task automatic run_traffic(input int n);
    int   span_ms, mv, roll;
    cmd_t c;
    span_ms = int'(dc.persist > dc.hold ? dc.persist : dc.hold) / 6 + 30;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 6) begin
        strong_rf = !strong_rf;
        target_mv = strong_rf ? int'($urandom_range(0, int'(dc.sat_mv) + 150))
                              : int'($urandom_range(1700, 3200));
      end
      if ($urandom_range(99) < 85) begin
        clock_ms += $urandom_range(0, span_ms);
        mv   = target_mv + int'($urandom_range(0, 120)) - 60;
        roll = $urandom_range(99);
        c = roll < 93 ? CMD_SAMPLE : roll < 96 ? CMD_SEED : roll < 99 ? CMD_CAL : CMD_NONE;
        if (c == CMD_SEED) mv = $urandom_range(1500, 3000);
      end else begin
        mv = $urandom_range(0, 4095);
        c  = cmd_t'($urandom_range(0, 3));
        if ($urandom_range(3) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(0, 5 * span_ms);
      end
      if (mv < 0) mv = 0;
      if (mv > 4095) mv = 4095;
      offer_sample(c, 12'(mv), clock_ms);
    end
  endtask

  task automatic test_commands_and_extremes();
    offer_sample(CMD_SAMPLE, 12'd2100, 32'd0);
    offer_sample(CMD_SAMPLE, 12'd0, 32'hFFFF_FFFF);
    offer_sample(CMD_SEED, 12'd4095, 32'hFFFF_FFFF);
    offer_sample(CMD_SAMPLE, 12'd4095, 32'd1);
    offer_sample(CMD_NONE, 12'd0, 32'd0);
    offer_sample(CMD_CAL, 12'd4095, 32'd0);
    // empty span falls back; power clamps at the high end
    offer_sample(CMD_SEED, 12'd0, 32'd5);
    offer_sample(CMD_SAMPLE, 12'd4095, 32'd6);
    drain_readings();
    // alpha of zero behaves as one
    program_regs(0, 4095, 4095, 1000, 1000, 1000, 65535, 65535);
    offer_sample(CMD_SAMPLE, 12'd4095, 32'd7);
    drain_readings();
  endtask

  task automatic test_persistence_hysteresis();
    // alpha above 256 behaves as 256; burst threshold of zero
    program_regs(300, 0, 500, 20, 300, 150, 100, 200);
    offer_sample(CMD_SEED, 12'd2100, 32'd0);
    offer_sample(CMD_SAMPLE, 12'd400, 32'd0);
    offer_sample(CMD_SAMPLE, 12'd400, 32'd50);
    offer_sample(CMD_SAMPLE, 12'd400, 32'd100);
    offer_sample(CMD_SAMPLE, 12'd2100, 32'd150);
    offer_sample(CMD_SAMPLE, 12'd2101, 32'd300);
    // candidate runs across the timestamp wrap
    offer_sample(CMD_SAMPLE, 12'd0, 32'hFFFF_FFC0);
    offer_sample(CMD_SAMPLE, 12'd0, 32'h0000_0030);
    offer_sample(CMD_SEED, 12'd2000, 32'h0000_0040);
    offer_sample(CMD_CAL, 12'd2000, 32'h0000_0050);
    offer_sample(CMD_SAMPLE, 12'd1500, 32'h0000_0060);
    offer_sample(CMD_SAMPLE, 12'd1900, 32'h0000_0200);
    drain_readings();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        src_idle = 46;
        snk_idle = 12;
      end
      if (ph == 6) begin
        src_idle = 0;
        snk_idle = 0;
      end
      case (ph)
        0: program_regs(26, 50, 500, 20, 300, 150, 500, 2000);
        1: program_regs(256, 0, 0, 0, 0, 0, 0, 0);
        2: program_regs(1, 4095, 4095, 1000, 1000, 1000, 65535, 65535);
        3: program_regs(511, 100, 800, 50, 400, 200, 300, 600);
        4: program_regs(0, 30, 300, 10, 250, 100, 150, 400);
        default: program_regs($urandom_range(0, 511), $urandom_range(0, 4095),
                              $urandom_range(0, 2500), $urandom_range(0, 200),
                              $urandom_range(0, 1000), $urandom_range(0, 1000),
                              $urandom_range(0, 3000), $urandom_range(0, 3000));
      endcase
      clock_ms = $urandom_range(1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 3000);
      offer_sample(CMD_SEED, 12'($urandom_range(1800, 2600)), clock_ms);
      run_traffic(200);
      drain_readings();
    end
  endtask

  task automatic test_backpressure();
    // hold the result side off long enough for the block to stall its input
    fork
      begin
        hold_back <= 1'b1;
        repeat (400) @(posedge clk);
        hold_back <= 1'b0;
      end
    join_none
    run_traffic(60);
    drain_readings();
  endtask

  always @(posedge clk) out_tready <= !hold_back && ($urandom_range(99) >= snk_idle);

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (readings_due.size() == 0) begin
        flag_mismatch("reading with nothing owed", 0, 0);
      end else begin
        want = readings_due.pop_front();
        if (out_tdata[19:0] !== want.filtered_q8)
          flag_mismatch("filtered_q8", out_tdata[19:0], want.filtered_q8);
        if (out_tdata[31:20] !== want.power_dbm_q4)
          flag_mismatch("power_dbm_q4", $signed(out_tdata[31:20]),
                        $signed(want.power_dbm_q4));
        if (out_tdata[41:32] !== want.threat_tenths)
          flag_mismatch("threat_tenths", out_tdata[41:32], want.threat_tenths);
        if (out_tuser[0] !== want.burst)
          flag_mismatch("burst", out_tuser[0], want.burst);
        if (out_tuser[1] !== want.incoming)
          flag_mismatch("incoming", out_tuser[1], want.incoming);
      end
      readings_seen++;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_SAMPLE;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_ALPHA;
    cfg_wdata  <= '0;
    hold_back  <= 1'b0;
    mismatches    = 0;
    readings_seen = 0;
    src_idle      = 12;
    snk_idle      = 46;
    clock_ms      = '0;
    target_mv     = 2100;
    strong_rf     = 1'b0;
    dc = '{alpha: 26, drop_mv: 50, sat_mv: 500, deadband: 20, trigger: 300,
           rel_tenths: 150, persist: 500, hold: 2000};
    avg_q8    = 20'(QUIESCENT_MV * 256);
    clean_q8  = 20'(QUIESCENT_MV * 256);
    prior_mv  = 12'(QUIESCENT_MV);
    alarm_on  = 1'b0;
    cand_live = 1'b0;
    cand_t0   = '0;
    active_t  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_commands_and_extremes();
    test_persistence_hysteresis();
    test_random_phases();
    test_backpressure();

    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/rfpd_pkg.sv
rtl/rfpd_cfg.sv
rtl/rfpd_div.sv
rtl/rf_power_detector_with_persistence.sv
rtl/rfpd_checker.sv
dv/tb_rf_power_detector_with_persistence.sv
